// ===== rtl/htx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package htx_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_BITS = 32;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_WZERO = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;

  typedef logic [CFG_W-1:0] cfg_word_t;

  // Identity matrix, one 64-bit word per column half.
  localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef struct packed {
    logic       dir;
    logic [3:0] ovf;
  } htx_flags_t;

endpackage

`default_nettype wire

// ===== rtl/htx_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htx_lane import htx_pkg::*; #(
  parameter int CB = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic                 dir_i,
  input  wire logic signed [CB-1:0] v0_i,
  input  wire logic signed [CB-1:0] v1_i,
  input  wire logic signed [CB-1:0] v2_i,
  input  wire cfg_word_t            col_lo_i,
  input  wire cfg_word_t            col_hi_i,
  output logic signed [CB-1:0]      res_o,
  output logic                      ovf_o
);

  localparam int PW = CB + COEF_BITS;
  localparam int SW = PW + 2;
  localparam int TW = SW - FRAC_BITS - CB + 1;
  localparam logic signed [SW-1:0] RND  = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  logic signed [COEF_BITS-1:0] c0, c1, c2, c3;
  logic signed [PW-1:0]        p3_d;
  logic signed [PW-1:0]        p0_q, p1_q, p2_q, p3_q;
  logic signed [PW:0]          s01_q, s23_q;
  logic signed [SW-1:0]        sum;
  logic [TW-1:0]               top;
  logic                        ovf_d;
  logic signed [CB-1:0]        res_d;
  logic signed [CB-1:0]        res_q;
  logic                        ovf_q;

  assign c0 = col_lo_i[31:0];
  assign c1 = col_lo_i[63:32];
  assign c2 = col_hi_i[31:0];
  assign c3 = col_hi_i[63:32];

  assign p3_d = dir_i ? '0 : ({{(PW-COEF_BITS){c3[COEF_BITS-1]}}, c3} << FRAC_BITS);

  assign sum   = SW'(s01_q) + SW'(s23_q) + RND;
  assign top   = sum[SW-1:FRAC_BITS+CB-1];
  assign ovf_d = !((&top) || (~|top));
  assign res_d = ovf_d ? (sum[SW-1] ? CMIN : CMAX) : sum[FRAC_BITS+CB-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= v0_i * c0;
      p1_q  <= v1_i * c1;
      p2_q  <= v2_i * c2;
      p3_q  <= p3_d;
      s01_q <= (PW+1)'(p0_q) + (PW+1)'(p1_q);
      s23_q <= (PW+1)'(p2_q) + (PW+1)'(p3_q);
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/htx_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htx_div import htx_pkg::*; #(
  parameter int CB = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [CB+FRAC_BITS-1:0] dvd_i,
  input  wire logic [CB-1:0]           dvs_i,
  output logic [CB:0]                  quo_o,
  output logic                         big_o
);

  localparam int NST = CB + 1;
  localparam int HW  = FRAC_BITS - 1;

  logic [CB-1:0] rem_q [NST+1];
  logic [CB:0]   low_q [NST+1];
  logic [CB:0]   quo_q [NST+1];
  logic [CB-1:0] dvs_q [NST+1];
  logic          big_q [NST+1];
  logic [CB-1:0] head;

  assign head = {{(CB-HW){1'b0}}, dvd_i[CB+FRAC_BITS-1:CB+1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= head;
      low_q[0] <= dvd_i[CB:0];
      quo_q[0] <= '0;
      dvs_q[0] <= dvs_i;
      big_q[0] <= head >= dvs_i;
    end
  end

  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic [CB:0] t;
    logic        ge;

    assign t  = {rem_q[j], low_q[j][CB-j]};
    assign ge = t >= {1'b0, dvs_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? CB'(t - {1'b0, dvs_q[j]}) : t[CB-1:0];
        low_q[j+1] <= low_q[j];
        quo_q[j+1] <= {quo_q[j][CB-1:0], ge};
        dvs_q[j+1] <= dvs_q[j];
        big_q[j+1] <= big_q[j];
      end
    end
  end

  assign quo_o = quo_q[NST];
  assign big_o = big_q[NST];

endmodule

`default_nettype wire

// ===== rtl/htx_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htx_merge import htx_pkg::*; #(
  parameter int CB = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire htx_flags_t           flags_i,
  input  wire logic signed [CB-1:0] r0_i,
  input  wire logic signed [CB-1:0] r1_i,
  input  wire logic signed [CB-1:0] r2_i,
  input  wire logic signed [CB-1:0] r3_i,
  output logic signed [CB-1:0]      x_o,
  output logic signed [CB-1:0]      y_o,
  output logic signed [CB-1:0]      z_o,
  output logic [1:0]                status_o
);

  localparam int DL = CB + 2;
  localparam logic signed [CB-1:0] CMAX  = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN  = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB:0]          LIM_P = {2'b00, {(CB-1){1'b1}}};
  localparam logic [CB:0]          LIM_N = {2'b01, {(CB-1){1'b0}}};

  logic signed [CB-1:0] num [3];
  logic signed [CB-1:0] res_d [3];
  logic                 dovf [3];
  logic [CB-1:0]        uw;
  logic                 wzero_d, pass_d, ovf_dot_d;

  logic signed [CB-1:0] num_dl_q [3][DL];
  logic                 neg_dl_q [3][DL];
  logic                 wzero_dl_q [DL];
  logic                 pass_dl_q [DL];
  logic                 ovf_dl_q [DL];

  logic signed [CB-1:0] x_q, y_q, z_q;
  logic [1:0]           status_q;
  logic [1:0]           status_d;
  logic                 wz, ps;

  assign num[0] = r0_i;
  assign num[1] = r1_i;
  assign num[2] = r2_i;

  assign uw        = r3_i[CB-1] ? (~r3_i + 1'b1) : r3_i;
  assign wzero_d   = !flags_i.dir && (r3_i == '0);
  assign pass_d    = flags_i.dir || ({{2{r3_i[CB-1]}}, r3_i} == (CB+2)'(ONE_Q));
  assign ovf_dot_d = (|flags_i.ovf[2:0]) || (!flags_i.dir && flags_i.ovf[3]);

  assign wz = wzero_dl_q[DL-1];
  assign ps = pass_dl_q[DL-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wzero_dl_q[0] <= wzero_d;
      pass_dl_q[0]  <= pass_d;
      ovf_dl_q[0]   <= ovf_dot_d;
      for (int k = 1; k < DL; k++) begin
        wzero_dl_q[k] <= wzero_dl_q[k-1];
        pass_dl_q[k]  <= pass_dl_q[k-1];
        ovf_dl_q[k]   <= ovf_dl_q[k-1];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [CB-1:0]           un;
    logic [CB+FRAC_BITS-1:0] dvd;
    logic [CB:0]             quo;
    logic                    big;
    logic                    neg;
    logic                    dov;
    logic signed [CB-1:0]    qv;
    logic signed [CB-1:0]    nv;

    assign un  = num[g][CB-1] ? (~num[g] + 1'b1) : num[g];
    assign dvd = {un, {FRAC_BITS{1'b0}}} + (CB+FRAC_BITS)'(uw >> 1);

    htx_div #(.CB(CB)) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .dvd_i (dvd),
      .dvs_i (uw),
      .quo_o (quo),
      .big_o (big)
    );

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_dl_q[g][0] <= num[g];
        neg_dl_q[g][0] <= num[g][CB-1] ^ r3_i[CB-1];
        for (int k = 1; k < DL; k++) begin
          num_dl_q[g][k] <= num_dl_q[g][k-1];
          neg_dl_q[g][k] <= neg_dl_q[g][k-1];
        end
      end
    end

    assign neg = neg_dl_q[g][DL-1];
    assign nv  = num_dl_q[g][DL-1];
    assign dov = big || (neg ? (quo > LIM_N) : (quo > LIM_P));
    assign qv  = neg ? (dov ? CMIN : CB'(~quo + 1'b1)) : (dov ? CMAX : quo[CB-1:0]);

    always_comb begin
      if (wz) begin
        res_d[g] = nv[CB-1] ? CMIN : ((|nv) ? CMAX : '0);
      end else if (ps) begin
        res_d[g] = nv;
      end else begin
        res_d[g] = qv;
      end
    end

    assign dovf[g] = !wz && !ps && dov;
  end

  always_comb begin
    if (wz) begin
      status_d = STATUS_WZERO;
    end else if (ovf_dl_q[DL-1] || dovf[0] || dovf[1] || dovf[2]) begin
      status_d = STATUS_OVF;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= res_d[0];
      y_q      <= res_d[1];
      z_q      <= res_d[2];
      status_q <= status_d;
    end
  end

  assign x_o      = x_q;
  assign y_o      = y_q;
  assign z_o      = z_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ===== rtl/homogeneous_point_transform_top.sv =====
// Throughput: one item per cycle; the whole pipeline advances together and stalls
// only while the output register holds a result that has not been taken.
// The depth is set by the three dividers, which resolve one quotient bit per stage.
// Reset clears all valid bits and loads the identity matrix into the registers.
`timescale 1ns / 1ps
`default_nettype none

module homogeneous_point_transform_top import htx_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         mode_i,
  input  wire logic signed [COORD_BITS-1:0] x_in_i,
  input  wire logic signed [COORD_BITS-1:0] y_in_i,
  input  wire logic signed [COORD_BITS-1:0] z_in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0]      x_out_o,
  output logic signed [COORD_BITS-1:0]      y_out_o,
  output logic signed [COORD_BITS-1:0]      z_out_o,
  output logic [1:0]                        status_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire cfg_word_t                    cfg_data_i
);

  localparam int CB  = COORD_BITS;
  localparam int LAT = CB + 7;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  cfg_word_t            cfg_q [NUM_REGS];
  logic [LAT-1:0]       vld_q;
  logic                 en;
  logic                 dir_q;
  logic [2:0]           dir_dl_q;
  logic signed [CB-1:0] x_q, y_q, z_q;
  logic signed [CB-1:0] r [4];
  logic [3:0]           lane_ovf;
  htx_flags_t           flags;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= CFG_RESET[i];
      end
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_q    <= mode_i;
      x_q      <= x_in_i;
      y_q      <= y_in_i;
      z_q      <= z_in_i;
      dir_dl_q <= {dir_dl_q[1:0], dir_q};
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    htx_lane #(.CB(CB)) u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .dir_i    (dir_q),
      .v0_i     (x_q),
      .v1_i     (y_q),
      .v2_i     (z_q),
      .col_lo_i (cfg_q[2*g]),
      .col_hi_i (cfg_q[2*g+1]),
      .res_o    (r[g]),
      .ovf_o    (lane_ovf[g])
    );
  end

  assign flags.dir = dir_dl_q[2];
  assign flags.ovf = lane_ovf;

  htx_merge #(.CB(CB)) u_merge (
    .clk_i    (clk_i),
    .en_i     (en),
    .flags_i  (flags),
    .r0_i     (r[0]),
    .r1_i     (r[1]),
    .r2_i     (r[2]),
    .r3_i     (r[3]),
    .x_o      (x_out_o),
    .y_o      (y_out_o),
    .z_o      (z_out_o),
    .status_o (status_o)
  );

  a_wzero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_WZERO) |->
      (x_out_o == CMAX || x_out_o == CMIN || x_out_o == '0))
    else $error("w-zero result not saturated");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
